>>> src/fwbc_pkg.sv
`default_nettype none

package fwbc_pkg;

    localparam int SLOT_COUNT        = 16;
    localparam int BLOCK_NUMBER_BITS = 16;
    localparam int SLOT_IDX_W        = $clog2(SLOT_COUNT);
    localparam int CNT_W             = $clog2(SLOT_COUNT + 1);
    localparam int CFG_W             = 5;
    localparam int MODE_W            = 2;
    localparam int BLOCK_PORT_W      = 16;
    localparam int SLOT_PORT_W       = 4;

    typedef logic [BLOCK_NUMBER_BITS-1:0] t_tag;
    typedef logic [SLOT_IDX_W-1:0]        t_slot;
    typedef logic [CNT_W-1:0]             t_cnt;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_WRITE  = 2'd1,
        MODE_FILL   = 2'd2,
        MODE_MARK   = 2'd3
    } t_mode;

    typedef struct packed {
        logic                  found;
        t_slot                 low;
        t_slot                 high;
        logic [SLOT_COUNT-1:0] hits;
    } t_match;

endpackage

`default_nettype wire

>>> src/fwbc_match.sv
`default_nettype none

module fwbc_match (
    input  wire logic [fwbc_pkg::SLOT_COUNT-1:0] i_valid,
    input  wire fwbc_pkg::t_tag                  i_tags [fwbc_pkg::SLOT_COUNT],
    input  wire fwbc_pkg::t_cnt                  i_live_cnt,
    input  wire fwbc_pkg::t_tag                  i_tag,
    output fwbc_pkg::t_match                     o_match
);
    import fwbc_pkg::*;

    logic [SLOT_COUNT-1:0] hits;
    t_slot                 low;
    t_slot                 high;

    // parallel compare over active slots
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            hits[i] = i_valid[i] && (i_tags[i] == i_tag) && (CNT_W'(i) < i_live_cnt);
        end
    end

    always_comb begin
        low  = '0;
        high = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (hits[i]) begin
                low = SLOT_IDX_W'(i);
            end
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (hits[i]) begin
                high = SLOT_IDX_W'(i);
            end
        end
    end

    assign o_match.found = |hits;
    assign o_match.low   = low;
    assign o_match.high  = high;
    assign o_match.hits  = hits;

endmodule

`default_nettype wire

>>> src/fifo_write_back_block_cache_tags_top.sv
// a request is held in the request register, then its result in the result register, o_done for one cycle
// throughput: one request per cycle, busy stays low; tags are compared in parallel
//   and the slot state is updated in the same cycle as the result register
// the receiver cannot stall; results are never held back
// reset (synchronous, active low): all slots empty and clean, insert pointer 0,
//   not wrapped, active_slots 16; no clearing pass
`default_nettype none

module fifo_write_back_block_cache_tags_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fwbc_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [fwbc_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [fwbc_pkg::BLOCK_PORT_W-1:0] i_block_number,
    output logic                                   o_done,
    output logic                                   o_hit,
    output logic [fwbc_pkg::SLOT_PORT_W-1:0]       o_slot,
    output logic                                   o_evict_valid,
    output logic [fwbc_pkg::BLOCK_PORT_W-1:0]      o_evict_block
);
    import fwbc_pkg::*;

    // configuration
    logic [CFG_W-1:0]      r_active;

    // request register
    logic                  r_req_valid;
    t_mode                 r_mode;
    logic [BLOCK_PORT_W-1:0] r_block;

    // slot state
    logic [SLOT_COUNT-1:0] r_slot_valid;
    logic [SLOT_COUNT-1:0] r_slot_dirty;
    t_tag                  r_slot_tag [SLOT_COUNT];
    t_slot                 r_ptr;
    logic                  r_wrapped;

    // result register
    logic                  r_done;
    logic                  r_hit;
    t_slot                 r_slot;
    logic                  r_ev;
    t_tag                  r_ev_blk;

    t_cnt                  live_cnt;
    t_tag                  req_tag;
    t_match                match;

    t_slot                 n_slot;
    logic                  n_ev;
    t_tag                  n_ev_blk;
    logic                  n_take;
    logic                  n_mark;
    logic                  n_advance;
    t_slot                 n_ptr;
    logic                  n_wrapped;

    assign busy = 1'b0;

    always_comb begin
        if (r_active == '0) begin
            live_cnt = CNT_W'(1);
        end else if (r_active > CFG_W'(SLOT_COUNT)) begin
            live_cnt = CNT_W'(SLOT_COUNT);
        end else begin
            live_cnt = CNT_W'(r_active);
        end
    end

    assign req_tag = r_block[BLOCK_NUMBER_BITS-1:0];

    fwbc_match u_match (
        .i_valid    (r_slot_valid),
        .i_tags     (r_slot_tag),
        .i_live_cnt (live_cnt),
        .i_tag      (req_tag),
        .o_match    (match)
    );

    always_comb begin
        n_slot    = '0;
        n_ev      = 1'b0;
        n_ev_blk  = '0;
        n_take    = 1'b0;
        n_mark    = 1'b0;
        n_advance = 1'b0;
        unique case (r_mode) inside
            MODE_LOOKUP: begin
                n_slot = match.found ? match.low : '0;
            end
            MODE_MARK: begin
                n_slot = match.found ? match.low : '0;
                n_mark = r_req_valid;
            end
            MODE_WRITE, MODE_FILL: begin
                n_take    = r_req_valid;
                n_advance = r_req_valid;
                if (r_mode == MODE_WRITE && match.found) begin
                    n_slot = match.high;
                end else begin
                    n_slot = r_ptr;
                    if (r_wrapped && r_slot_dirty[r_ptr]) begin
                        n_ev     = 1'b1;
                        n_ev_blk = r_slot_tag[r_ptr];
                    end
                end
            end
            default: begin
                n_slot = '0;
            end
        endcase
    end

    // fifo insert pointer
    always_comb begin
        n_ptr     = r_ptr;
        n_wrapped = r_wrapped;
        if (n_advance) begin
            if ({1'b0, r_ptr} + CNT_W'(1) >= live_cnt) begin
                n_ptr     = '0;
                n_wrapped = 1'b1;
            end else begin
                n_ptr = r_ptr + SLOT_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= CFG_W'(SLOT_COUNT);
            r_req_valid  <= 1'b0;
            r_done       <= 1'b0;
            r_slot_valid <= '0;
            r_slot_dirty <= '0;
            r_ptr        <= '0;
            r_wrapped    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_data;
            end
            r_req_valid <= start && !busy;
            r_done      <= r_req_valid;
            r_ptr       <= n_ptr;
            r_wrapped   <= n_wrapped;
            if (n_mark) begin
                r_slot_dirty <= r_slot_dirty | match.hits;
            end
            if (n_take) begin
                r_slot_valid[n_slot] <= 1'b1;
                r_slot_dirty[n_slot] <= (r_mode == MODE_WRITE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mode  <= t_mode'(i_mode);
            r_block <= i_block_number;
        end
        if (n_take) begin
            r_slot_tag[n_slot] <= req_tag;
        end
        r_hit    <= match.found;
        r_slot   <= n_slot;
        r_ev     <= n_ev;
        r_ev_blk <= n_ev_blk;
    end

    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_slot        = SLOT_PORT_W'(r_slot);
    assign o_evict_valid = r_ev;
    assign o_evict_block = BLOCK_PORT_W'(r_ev_blk);

    // a request always yields a result on o_done, through the request and result registers
    a_req_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("request without result");

    // dirty slots are always valid
    a_dirty_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_slot_dirty & ~r_slot_valid) == '0)
        else $error("dirty slot not valid");

    // a victim only on write or fill after the pointer has wrapped
    a_ev_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && n_ev) |-> (r_wrapped && (r_mode == MODE_WRITE || r_mode == MODE_FILL)))
        else $error("victim without wrap");

    // no victim reported means a zero victim block
    a_ev_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_evict_valid) |-> (o_evict_block == '0))
        else $error("stale victim block");

    // the pointer stays inside the slot array
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_ptr} < CNT_W'(SLOT_COUNT))
        else $error("insert pointer out of range");

endmodule

`default_nettype wire

>>> tb/sv/fwbc_tag_checker.sv
`timescale 1ns / 100ps

module fwbc_tag_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [fwbc_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              i_start,
    input  wire logic                              i_busy,
    input  wire logic [fwbc_pkg::MODE_W-1:0]       i_mode,
    input  wire logic [fwbc_pkg::BLOCK_PORT_W-1:0] i_block_number,
    input  wire logic                              i_done,
    input  wire logic                              i_hit,
    input  wire logic [fwbc_pkg::SLOT_PORT_W-1:0]  i_slot,
    input  wire logic                              i_evict_valid,
    input  wire logic [fwbc_pkg::BLOCK_PORT_W-1:0] i_evict_block,
    output int                                     o_fail_count,
    output int                                     o_pending
);
    import fwbc_pkg::*;

    typedef struct packed {
        logic                    hit;
        logic [SLOT_PORT_W-1:0]  slot;
        logic                    evict_valid;
        logic [BLOCK_PORT_W-1:0] evict_block;
    } t_cache_result;

    bit             slot_valid [SLOT_COUNT];
    t_tag           slot_tag   [SLOT_COUNT];
    bit             slot_dirty [SLOT_COUNT];
    t_slot          insert_ptr;
    bit             wrapped;
    logic [CFG_W-1:0] active_cfg;
    t_cache_result  expected_q [$];
    int             fail_count = 0;

    assign o_fail_count = fail_count;

    initial o_pending = 0;

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        fail_count++;
    endtask

    function automatic t_cache_result serve_request(input t_mode m, input t_tag blk);
        t_cache_result r;
        int  n;
        bit  found;
        int  low;
        int  high;
        int  s;
        n     = (active_cfg == 0) ? 1 : ((active_cfg > SLOT_COUNT) ? SLOT_COUNT : active_cfg);
        found = 1'b0;
        low   = 0;
        high  = 0;
        s     = 0;
        r     = '0;
        for (int i = 0; i < n; i++) begin
            if (slot_valid[i] && slot_tag[i] == blk) begin
                if (!found) low = i;
                high  = i;
                found = 1'b1;
            end
        end
        case (m)
            MODE_LOOKUP: begin
                s = found ? low : 0;
            end
            MODE_MARK: begin
                s = found ? low : 0;
                for (int i = 0; i < n; i++)
                    if (slot_valid[i] && slot_tag[i] == blk) slot_dirty[i] = 1'b1;
            end
            default: begin
                if (m == MODE_WRITE && found) begin
                    s = high;
                end else begin
                    s = insert_ptr;
                    if (wrapped && slot_dirty[s]) begin
                        r.evict_valid = 1'b1;
                        r.evict_block = slot_tag[s];
                    end
                end
                slot_valid[s] = 1'b1;
                slot_tag[s]   = blk;
                slot_dirty[s] = (m == MODE_WRITE);
                if (int'(insert_ptr) + 1 >= n) begin
                    insert_ptr = '0;
                    wrapped    = 1'b1;
                end else begin
                    insert_ptr = insert_ptr + 1'b1;
                end
            end
        endcase
        r.hit  = found;
        r.slot = s[SLOT_PORT_W-1:0];
        return r;
    endfunction

    task automatic compare_result(input t_cache_result got, input t_cache_result want);
        if (got.hit !== want.hit)
            report_mismatch($sformatf("hit got %0b want %0b", got.hit, want.hit));
        if (got.slot !== want.slot)
            report_mismatch($sformatf("slot got %0d want %0d", got.slot, want.slot));
        if (got.evict_valid !== want.evict_valid)
            report_mismatch($sformatf("evict_valid got %0b want %0b",
                                      got.evict_valid, want.evict_valid));
        if (got.evict_block !== want.evict_block)
            report_mismatch($sformatf("evict_block got %h want %h",
                                      got.evict_block, want.evict_block));
    endtask

    always @(posedge i_clk) begin
        t_cache_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_valid[i] = 1'b0;
                slot_tag[i]   = '0;
                slot_dirty[i] = 1'b0;
            end
            insert_ptr = '0;
            wrapped    = 1'b0;
            active_cfg = CFG_W'(SLOT_COUNT);
            expected_q.delete();
        end else begin
            if (i_done) begin
                got = '{i_hit, i_slot, i_evict_valid, i_evict_block};
                if (expected_q.size() == 0)
                    report_mismatch("result with no request outstanding");
                else
                    compare_result(got, expected_q.pop_front());
            end
            if (i_cfg_we) active_cfg = i_cfg_data;
            if (i_start && !i_busy)
                expected_q.push_back(serve_request(t_mode'(i_mode), t_tag'(i_block_number)));
        end
        o_pending <= expected_q.size();
    end

endmodule

>>> tb/sv/tb_fifo_write_back_block_cache_tags_top.sv
`timescale 1ns / 100ps

module tb_fifo_write_back_block_cache_tags_top;
    import fwbc_pkg::*;

    logic                    i_clk          = 1'b0;
    logic                    i_rst_n        = 1'b0;
    logic                    i_cfg_we       = 1'b0;
    logic [CFG_W-1:0]        i_cfg_data     = '0;
    logic                    start          = 1'b0;
    logic [MODE_W-1:0]       i_mode         = '0;
    logic [BLOCK_PORT_W-1:0] i_block_number = '0;
    logic                    busy;
    logic                    o_done;
    logic                    o_hit;
    logic [SLOT_PORT_W-1:0]  o_slot;
    logic                    o_evict_valid;
    logic [BLOCK_PORT_W-1:0] o_evict_block;
    int                      fail_count;
    int                      pending;

    logic [BLOCK_PORT_W-1:0] tag_pool [20];
    int                      pool_size;

    fifo_write_back_block_cache_tags_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_block_number (i_block_number),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_slot         (o_slot),
        .o_evict_valid  (o_evict_valid),
        .o_evict_block  (o_evict_block)
    );

    fwbc_tag_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_start        (start),
        .i_busy         (busy),
        .i_mode         (i_mode),
        .i_block_number (i_block_number),
        .i_done         (o_done),
        .i_hit          (o_hit),
        .i_slot         (o_slot),
        .i_evict_valid  (o_evict_valid),
        .i_evict_block  (o_evict_block),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic send_request(input t_mode m, input logic [BLOCK_PORT_W-1:0] b);
        @(negedge i_clk);
        start          = 1'b1;
        i_mode         = m;
        i_block_number = b;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_gaps(input int pct);
        while ($urandom_range(99) < pct) begin
            @(negedge i_clk);
            start = 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start = 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_active_slots(input logic [CFG_W-1:0] v);
        drain_results();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    function automatic logic [BLOCK_PORT_W-1:0] pick_block();
        int r;
        r = $urandom_range(99);
        if (r < 75) return tag_pool[$urandom_range(pool_size - 1)];
        if (r < 80) return '0;
        if (r < 85) return '1;
        return BLOCK_PORT_W'($urandom);
    endfunction

    initial begin
        logic [CFG_W-1:0] phase_cfg [10];
        int               phase_idle [10];
        phase_cfg  = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd17, 5'd2, 5'd8, 5'd16, 5'd5};
        phase_idle = '{0, 59, 22, 59, 0, 22, 59, 22, 0, 59};

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty cache, hits, duplicates, lowest and highest match
        send_request(MODE_LOOKUP, 16'h0000);
        send_request(MODE_FILL,   16'h0000);
        send_request(MODE_FILL,   16'hFFFF);
        send_request(MODE_LOOKUP, 16'h0000);
        send_request(MODE_LOOKUP, 16'hFFFF);
        send_request(MODE_WRITE,  16'h0000);
        send_request(MODE_WRITE,  16'h1234);
        send_request(MODE_MARK,   16'hFFFF);
        send_request(MODE_MARK,   16'h5555);
        send_request(MODE_FILL,   16'hFFFF);
        send_request(MODE_LOOKUP, 16'hFFFF);
        send_request(MODE_WRITE,  16'hFFFF);
        send_request(MODE_MARK,   16'hFFFF);
        send_request(MODE_LOOKUP, 16'hAAAA);

        // pointer beyond a reduced count, then dirty victims after wrap
        set_active_slots(5'd2);
        send_request(MODE_WRITE,  16'h8001);
        send_request(MODE_FILL,   16'h7FFE);
        send_request(MODE_WRITE,  16'h00FF);
        send_request(MODE_FILL,   16'h0F0F);
        send_request(MODE_WRITE,  16'h0F0F);
        send_request(MODE_LOOKUP, 16'h8001);
        send_request(MODE_FILL,   16'hF0F0);

        set_active_slots(5'd0);
        send_request(MODE_WRITE,  16'h1111);
        send_request(MODE_FILL,   16'h2222);

        set_active_slots(5'd31);
        send_request(MODE_LOOKUP, 16'h8001);

        for (int p = 0; p < 10; p++) begin
            set_active_slots((p == 9) ? CFG_W'($urandom) : phase_cfg[p]);
            pool_size = $urandom_range(2, 20);
            for (int k = 0; k < pool_size; k++) tag_pool[k] = BLOCK_PORT_W'($urandom);
            for (int j = 0; j < 50; j++) begin
                if ((p == 2 && j == 25) || $urandom_range(99) == 0) drain_results();
                idle_gaps(phase_idle[p]);
                send_request(t_mode'($urandom_range(3)), pick_block());
            end
        end

        drain_results();
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
